// ----- rtl/core/mrd_pkg.sv -----
// ----------------------------------------------------------------------------
// mrd_pkg
// Shared types and constants for the Modbus RTU response deframer.
// ----------------------------------------------------------------------------
package mrd_pkg;

   localparam int MAX_FRAME_DEF = 256;

   localparam int BYTE_W   = 8;
   localparam int LEN_W    = 9;
   localparam int CRC_W    = 16;
   localparam int RSP_W    = 32;

   localparam logic [CRC_W-1:0]  CRC_INIT       = 16'hFFFF;
   localparam logic [CRC_W-1:0]  CRC_POLY       = 16'hA001;
   localparam logic [BYTE_W-1:0] FC_COUNT_LIMIT = 8'h05;
   localparam int                FC_EXC_BIT     = 7;
   localparam logic [BYTE_W-1:0] ADDR_FIELD_LEN = 8'd2;
   localparam logic [BYTE_W-1:0] SLAVE_ADDR_RST = 8'd1;

   // req_tuser codes
   localparam logic ACT_BYTE   = 1'b0;
   localparam logic ACT_RESYNC = 1'b1;

   typedef enum logic [2:0] {
      ST_NONE      = 3'd0,
      ST_ACCEPTED  = 3'd1,
      ST_EXCEPTION = 3'd2,
      ST_CRC_ERROR = 3'd3,
      ST_OVERFLOW  = 3'd4
   } status_type;

   typedef struct packed {
      logic [BYTE_W-1:0] byte_echo;
      logic [BYTE_W-1:0] byte_position;
      logic              in_frame;
      status_type        frame_status;
      logic [LEN_W-1:0]  frame_length;
   } result_type;

endpackage

// ----- rtl/core/modbus_rtu_response_deframer.sv -----
// ----------------------------------------------------------------------------
// modbus_rtu_response_deframer
// Byte-stream deframer for Modbus RTU responses with CRC-16/MODBUS check.
// ----------------------------------------------------------------------------
// One received byte is taken per clock when the result register is free and
// produces exactly one result beat, which appears in the result register in
// the cycle after the byte is accepted. Throughput is one byte per cycle
// whenever the result side keeps up; the rate is set by the combinational
// parser step and 8-bit CRC update that sit between the parser state
// registers and the result register. A stalled result side holds off new
// bytes only while the result register is full. slave_address resets to 1
// and should be written only while no byte is in flight.
module modbus_rtu_response_deframer #(
   parameter int MAX_FRAME = mrd_pkg::MAX_FRAME_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // config: slave_address
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic        req_tuser,   // [0] action (1 = resync)
   // response stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // [7:0] byte_echo, [15:8] byte_position,
                                    // [16] in_frame, [19:17] frame_status,
                                    // [28:20] frame_length, [31:29] zero
);
   import mrd_pkg::*;

   logic [7:0]  slave_address_ff;
   logic        accept;
   logic        free;
   result_type  result;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         slave_address_ff <= SLAVE_ADDR_RST;
      end else if (csr_valid && csr_ready) begin
         slave_address_ff <= csr_data;
      end
   end

   assign req_tready    = free;
   assign accept        = req_tvalid && free;

   mrd_parser #(
      .MAX_FRAME (MAX_FRAME)
   ) u_parser (
      .clock         (clock),
      .reset         (reset),
      .beat_accept   (accept),
      .action        (req_tuser),
      .rx_byte       (req_tdata),
      .slave_address (slave_address_ff),
      .result        (result)
   );

   mrd_out_reg u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (accept),
      .result     (result),
      .free       (free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

`ifndef SYNTHESIS
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |-> (!rsp_tvalid || rsp_tready))
      else $error("result overwritten while stalled");

   a_resync_zero: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && (req_tuser == ACT_RESYNC))
         |=> (rsp_tvalid && (rsp_tdata == 32'd0)))
      else $error("resync result not all zero");

   a_done_len: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && ((rsp_tdata[19:17] == ST_ACCEPTED)
                   || (rsp_tdata[19:17] == ST_EXCEPTION)
                   || (rsp_tdata[19:17] == ST_CRC_ERROR)))
         |-> (rsp_tdata[16] && (rsp_tdata[28:20] != 9'd0)))
      else $error("completed frame without length");

   a_pos_unkept: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tdata[16]) |-> (rsp_tdata[15:8] == 8'd0))
      else $error("position set on byte outside a frame");
`endif

endmodule

// ----- rtl/core/mrd_crc16.sv -----
// ----------------------------------------------------------------------------
// mrd_crc16
// One-byte update of CRC-16/MODBUS (reflected, poly 0xA001).
// ----------------------------------------------------------------------------
module mrd_crc16 (
   input  logic [15:0] crc_in,
   input  logic [7:0]  data_in,
   output logic [15:0] crc_out
);
   import mrd_pkg::*;

   always_comb begin
      logic [CRC_W-1:0] c;
      c = crc_in ^ {8'h00, data_in};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      crc_out = c;
   end

endmodule

// ----- rtl/core/mrd_parser.sv -----
// ----------------------------------------------------------------------------
// mrd_parser
// Frame parser state and per-byte step; result is combinational off state and inputs.
// ----------------------------------------------------------------------------
module mrd_parser #(
   parameter int MAX_FRAME = mrd_pkg::MAX_FRAME_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               beat_accept,
   input  logic               action,
   input  logic [7:0]         rx_byte,
   input  logic [7:0]         slave_address,
   output mrd_pkg::result_type result
);
   import mrd_pkg::*;

   localparam int CNT_W = $clog2(MAX_FRAME + 1);

   typedef enum logic [2:0] {
      PH_HUNT  = 3'd0,
      PH_FUNC  = 3'd1,
      PH_COUNT = 3'd2,
      PH_ADDR  = 3'd3,
      PH_DATA  = 3'd4,
      PH_CRC   = 3'd5
   } phase_type;

   phase_type         phase_ff, phase_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [7:0]        pcnt_ff, pcnt_in;
   logic [7:0]        dlen_ff, dlen_in;
   logic [CRC_W-1:0]  crc_ff, crc_in;
   logic [7:0]        crc_lo_ff, crc_lo_in;
   logic [7:0]        func_ff, func_in;

   logic              ovf;
   phase_type         ph_e;
   logic [CNT_W-1:0]  pos;
   logic [7:0]        pcnt_e, pcnt_inc, dlen_e, crc_lo_e, func_e;
   logic [CRC_W-1:0]  crc_e, crc_upd;
   logic              kept, done;
   status_type        status;
   logic [LEN_W-1:0]  pos9;

   // an overflowing byte first drops the frame, then is parsed from hunt
   assign ovf      = (phase_ff != PH_HUNT) && (count_ff >= CNT_W'(MAX_FRAME));
   assign ph_e     = ovf ? PH_HUNT : phase_ff;
   assign pos      = ovf ? '0 : count_ff;
   assign pcnt_e   = ovf ? '0 : pcnt_ff;
   assign dlen_e   = ovf ? '0 : dlen_ff;
   assign crc_lo_e = ovf ? '0 : crc_lo_ff;
   assign func_e   = ovf ? '0 : func_ff;
   assign crc_e    = ovf ? CRC_INIT : crc_ff;
   assign pcnt_inc = pcnt_e + 8'd1;
   assign pos9     = LEN_W'(pos);

   mrd_crc16 u_crc (
      .crc_in  (crc_e),
      .data_in (rx_byte),
      .crc_out (crc_upd)
   );

   always_comb begin
      phase_in  = ph_e;
      pcnt_in   = pcnt_e;
      dlen_in   = dlen_e;
      crc_in    = crc_e;
      crc_lo_in = crc_lo_e;
      func_in   = func_e;
      kept      = 1'b1;
      done      = 1'b0;
      status    = ovf ? ST_OVERFLOW : ST_NONE;

      case (ph_e)
         PH_FUNC: begin
            func_in  = rx_byte;
            crc_in   = crc_upd;
            pcnt_in  = '0;
            phase_in = (rx_byte < FC_COUNT_LIMIT) ? PH_COUNT : PH_ADDR;
         end
         PH_COUNT: begin
            dlen_in  = rx_byte;
            crc_in   = crc_upd;
            pcnt_in  = '0;
            phase_in = (rx_byte == 8'd0) ? PH_CRC : PH_DATA;
         end
         PH_ADDR: begin
            crc_in  = crc_upd;
            pcnt_in = pcnt_inc;
            if (pcnt_inc == ADDR_FIELD_LEN) begin
               dlen_in  = ADDR_FIELD_LEN;
               pcnt_in  = '0;
               phase_in = PH_DATA;
            end
         end
         PH_DATA: begin
            crc_in  = crc_upd;
            pcnt_in = pcnt_inc;
            if (pcnt_inc == dlen_e) begin
               pcnt_in  = '0;
               phase_in = PH_CRC;
            end
         end
         PH_CRC: begin
            if (pcnt_e == 8'd0) begin
               crc_lo_in = rx_byte;
               pcnt_in   = 8'd1;
            end else begin
               done = 1'b1;
               if (func_e[FC_EXC_BIT]) begin
                  status = ST_EXCEPTION;
               end else if ({rx_byte, crc_lo_e} == crc_e) begin
                  status = ST_ACCEPTED;
               end else begin
                  status = ST_CRC_ERROR;
               end
            end
         end
         default: begin
            if (rx_byte == slave_address) begin
               crc_in   = crc_upd;
               phase_in = PH_FUNC;
            end else begin
               kept = 1'b0;
            end
         end
      endcase

      count_in = kept ? (pos + CNT_W'(1)) : pos;

      if (done || (action == ACT_RESYNC)) begin
         phase_in  = PH_HUNT;
         count_in  = '0;
         pcnt_in   = '0;
         dlen_in   = '0;
         crc_in    = CRC_INIT;
         crc_lo_in = '0;
         func_in   = '0;
      end

      if (action == ACT_RESYNC) begin
         result = '0;
      end else begin
         result.byte_echo     = rx_byte;
         result.byte_position = kept ? pos9[7:0] : 8'd0;
         result.in_frame      = kept;
         result.frame_status  = status;
         result.frame_length  = done ? (pos9 + LEN_W'(1)) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HUNT;
         count_ff  <= '0;
         pcnt_ff   <= '0;
         dlen_ff   <= '0;
         crc_ff    <= CRC_INIT;
         crc_lo_ff <= '0;
         func_ff   <= '0;
      end else if (beat_accept) begin
         phase_ff  <= phase_in;
         count_ff  <= count_in;
         pcnt_ff   <= pcnt_in;
         dlen_ff   <= dlen_in;
         crc_ff    <= crc_in;
         crc_lo_ff <= crc_lo_in;
         func_ff   <= func_in;
      end
   end

endmodule

// ----- rtl/core/mrd_out_reg.sv -----
// ----------------------------------------------------------------------------
// mrd_out_reg
// Result register with stream handshake; packs the result beat.
// ----------------------------------------------------------------------------
module mrd_out_reg (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  mrd_pkg::result_type result,
   output logic                free,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [31:0]         rsp_tdata
);
   import mrd_pkg::*;

   logic              valid_ff;
   logic [RSP_W-1:0]  data_ff, data_in;

   // taking a new beat is fine as long as the held one leaves this cycle
   assign free = !valid_ff || rsp_tready;

   assign data_in = {3'b000,
                     result.frame_length,
                     result.frame_status,
                     result.in_frame,
                     result.byte_position,
                     result.byte_echo};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         valid_ff <= 1'b0;
      end
      if (load) begin
         data_ff <= data_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;

endmodule

// ----- tb/tb_modbus_rtu_response_deframer.sv -----
// ----------------------------------------------------------------------------
// tb_modbus_rtu_response_deframer
// Self-checking bench for the Modbus RTU response deframer. Byte and resync
// beats go in on the request stream. A bit-accurate parser model, with its
// own CRC-16/MODBUS, predicts the report for each accepted beat. Every
// response beat is checked field by field against the oldest prediction.
// A short directed table comes first. Random frames follow under three
// slave addresses and three handshake idling mixes: well-formed frames,
// truncated frames, line noise, resyncs, the longest legal frame and
// frames that run past the frame limit.
// ----------------------------------------------------------------------------
module tb_modbus_rtu_response_deframer;
   import mrd_pkg::*;

   localparam int FRAME_MAX   = MAX_FRAME_DEF;
   localparam int CYCLE_LIMIT = 400000;

   typedef enum logic [2:0] {
      P_HUNT, P_FUNC, P_COUNT, P_ADDR, P_DATA, P_CRC
   } parse_phase_type;

   typedef enum logic [1:0] {RAW_BYTE, CRC_LOW_OK, CRC_HIGH_OK} row_kind_type;

   typedef struct {
      logic [7:0] echo;
      logic [7:0] pos;
      logic       kept;
      status_type status;
      logic [8:0] len;
   } byte_report_type;

   typedef struct {
      logic            act;
      row_kind_type    kind;
      logic [7:0]      data;
      bit              typed;
      byte_report_type want;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_data = 8'h00;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // [7:0] rx_byte
   logic        req_tuser = 1'b0;    // [0] action
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;           // [7:0] echo, [15:8] position, [16] in_frame,
                                     // [19:17] status, [28:20] length

   // parser model state
   logic [7:0]      slave_addr;
   parse_phase_type ph;
   logic [8:0]      stored;
   logic [7:0]      phase_cnt;
   logic [7:0]      data_len;
   logic [15:0]     crc;
   logic [7:0]      crc_lo;
   logic [7:0]      func;

   byte_report_type byte_reports[$];
   stim_row_type    dir_rows[$];
   logic [7:0]      frame_bytes[$];

   int send_idle_pct = 22;
   int rcv_idle_pct  = 65;
   int items_sent    = 0;
   int mismatches    = 0;
   int cycle_count   = 0;

   modbus_rtu_response_deframer #(
      .MAX_FRAME (FRAME_MAX)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d reports pending", cycle_count,
                  byte_reports.size());
         $display("DONE: errors detected");
         $finish;
      end
   end

   function automatic logic [15:0] crc16_update(logic [15:0] c, logic [7:0] b);
      logic [15:0] x;
      x = c ^ {8'h00, b};
      for (int i = 0; i < 8; i++)
         x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
      return x;
   endfunction

   function automatic void clear_parser();
      ph        = P_HUNT;
      stored    = '0;
      phase_cnt = '0;
      data_len  = '0;
      crc       = CRC_INIT;
      crc_lo    = '0;
      func      = '0;
   endfunction

   // one parser step; returns the report the block should give for this beat
   function automatic byte_report_type parse_rx_byte(logic act, logic [7:0] b);
      byte_report_type r;
      logic [8:0]      at;
      logic            kept;
      r.echo   = 8'h00;
      r.pos    = 8'h00;
      r.kept   = 1'b0;
      r.status = ST_NONE;
      r.len    = 9'd0;
      kept     = 1'b1;
      if (act == ACT_RESYNC) begin
         clear_parser();
         return r;
      end
      if (ph != P_HUNT && stored >= FRAME_MAX) begin
         clear_parser();
         r.status = ST_OVERFLOW;
      end
      at = stored;
      case (ph)
         P_FUNC: begin
            func      = b;
            crc       = crc16_update(crc, b);
            phase_cnt = '0;
            ph        = (b < FC_COUNT_LIMIT) ? P_COUNT : P_ADDR;
         end
         P_COUNT: begin
            data_len  = b;
            crc       = crc16_update(crc, b);
            phase_cnt = '0;
            ph        = (b == 8'h00) ? P_CRC : P_DATA;
         end
         P_ADDR: begin
            crc       = crc16_update(crc, b);
            phase_cnt = phase_cnt + 8'd1;
            if (phase_cnt == ADDR_FIELD_LEN) begin
               data_len  = ADDR_FIELD_LEN;
               phase_cnt = '0;
               ph        = P_DATA;
            end
         end
         P_DATA: begin
            crc       = crc16_update(crc, b);
            phase_cnt = phase_cnt + 8'd1;
            if (phase_cnt == data_len) begin
               phase_cnt = '0;
               ph        = P_CRC;
            end
         end
         P_CRC: begin
            if (phase_cnt == 8'h00) begin
               crc_lo    = b;
               phase_cnt = 8'd1;
            end else begin
               if (func[FC_EXC_BIT])
                  r.status = ST_EXCEPTION;
               else if ({b, crc_lo} == crc)
                  r.status = ST_ACCEPTED;
               else
                  r.status = ST_CRC_ERROR;
               r.len = at + 9'd1;
            end
         end
         default: begin
            if (b == slave_addr) begin
               crc = crc16_update(crc, b);
               ph  = P_FUNC;
            end else begin
               kept = 1'b0;
            end
         end
      endcase
      if (r.len != 9'd0)
         clear_parser();
      else if (kept)
         stored = at + 9'd1;
      r.echo = b;
      r.pos  = kept ? at[7:0] : 8'h00;
      r.kept = kept;
      return r;
   endfunction

   function automatic void add_row(logic act, row_kind_type kind, logic [7:0] b, bit typed,
                                   logic [7:0] w_pos, logic w_in, status_type w_st,
                                   logic [8:0] w_len);
      stim_row_type row;
      row.act         = act;
      row.kind        = kind;
      row.data        = b;
      row.typed       = typed;
      row.want.echo   = b;
      row.want.pos    = w_pos;
      row.want.kept   = w_in;
      row.want.status = w_st;
      row.want.len    = w_len;
      dir_rows.push_back(row);
   endfunction

   // response frame to the current slave address; the address path ignores n_data
   function automatic void build_frame(logic [7:0] fc, int n_data, bit good_crc);
      logic [15:0] c;
      int          n;
      frame_bytes.delete();
      frame_bytes.push_back(slave_addr);
      frame_bytes.push_back(fc);
      n = n_data;
      if (fc < FC_COUNT_LIMIT) begin
         frame_bytes.push_back(n_data[7:0]);
      end else begin
         frame_bytes.push_back(8'($urandom));
         frame_bytes.push_back(8'($urandom));
         n = 2;
      end
      for (int i = 0; i < n; i++)
         frame_bytes.push_back(8'($urandom));
      c = CRC_INIT;
      foreach (frame_bytes[i])
         c = crc16_update(c, frame_bytes[i]);
      if (!good_crc)
         c = c ^ 16'($urandom_range(1, 65535));
      frame_bytes.push_back(c[7:0]);
      frame_bytes.push_back(c[15:8]);
   endfunction

   task automatic send_item(logic act, logic [7:0] b);
      byte_report_type r;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      r = parse_rx_byte(act, b);
      byte_reports.push_back(r);
      items_sent++;
   endtask

   task automatic send_bytes(int n);
      for (int i = 0; i < n; i++)
         send_item(ACT_BYTE, frame_bytes[i]);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (byte_reports.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_slave_address(logic [7:0] v);
      csr_valid <= 1'b1;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid  <= 1'b0;
      slave_addr = v;
   endtask

   task automatic run_random(int n_items);
      int         stop_at;
      int         pick;
      int         n;
      logic [7:0] fc;
      stop_at = items_sent + n_items;
      while (items_sent < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 80) begin
            case ($urandom_range(4))
               0, 1:    fc = 8'($urandom_range(0, 4));
               2, 3:    fc = 8'($urandom_range(5, 127));
               default: fc = 8'($urandom_range(128, 255));
            endcase
            n = ($urandom_range(99) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
            build_frame(fc, n, $urandom_range(99) < 75);
            if (pick < 70) begin
               send_bytes(frame_bytes.size());
            end else begin
               // cut short; the next bytes either land in this frame or follow a resync
               send_bytes($urandom_range(1, frame_bytes.size() - 1));
               if ($urandom_range(1))
                  send_item(ACT_RESYNC, 8'($urandom));
            end
         end else if (pick < 92) begin
            repeat ($urandom_range(1, 6)) send_item(ACT_BYTE, 8'($urandom));
         end else begin
            send_item(ACT_RESYNC, 8'($urandom));
         end
      end
   endtask

   function automatic void flag_mismatch(string what, byte_report_type want,
                                         byte_report_type got);
      mismatches++;
      if (mismatches <= 10)
         $display({"%s: exp echo=%h pos=%0d in=%b st=%0d len=%0d,",
                   " got echo=%h pos=%0d in=%b st=%0d len=%0d"},
                  what, want.echo, want.pos, want.kept, want.status, want.len,
                  got.echo, got.pos, got.kept, got.status, got.len);
   endfunction

   always @(posedge clock) begin
      byte_report_type want;
      byte_report_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.echo   = rsp_tdata[7:0];
         got.pos    = rsp_tdata[15:8];
         got.kept   = rsp_tdata[16];
         got.status = status_type'(rsp_tdata[19:17]);
         got.len    = rsp_tdata[28:20];
         if (byte_reports.size() == 0) begin
            want.echo   = 8'h00;
            want.pos    = 8'h00;
            want.kept   = 1'b0;
            want.status = ST_NONE;
            want.len    = 9'd0;
            flag_mismatch("unexpected beat", want, got);
         end else begin
            want = byte_reports.pop_front();
            if (got.echo !== want.echo || got.pos !== want.pos || got.kept !== want.kept ||
                got.status !== want.status || got.len !== want.len)
               flag_mismatch("mismatch", want, got);
         end
      end
      rsp_tready <= ($urandom_range(99) >= rcv_idle_pct);
   end

   initial begin
      logic [7:0] b;
      slave_addr = SLAVE_ADDR_RST;
      clear_parser();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset address is 1
      add_row(ACT_BYTE,   RAW_BYTE,    8'h00, 1, 8'd0, 1'b0, ST_NONE, 9'd0);
      add_row(ACT_BYTE,   RAW_BYTE,    8'hFF, 1, 8'd0, 1'b0, ST_NONE, 9'd0);
      add_row(ACT_BYTE,   RAW_BYTE,    8'h01, 1, 8'd0, 1'b1, ST_NONE, 9'd0);
      add_row(ACT_RESYNC, RAW_BYTE,    8'h00, 1, 8'd0, 1'b0, ST_NONE, 9'd0);
      // count path, zero byte count, good CRC
      add_row(ACT_BYTE,   RAW_BYTE,    8'h01, 1, 8'd0, 1'b1, ST_NONE, 9'd0);
      add_row(ACT_BYTE,   RAW_BYTE,    8'h04, 1, 8'd1, 1'b1, ST_NONE, 9'd0);
      add_row(ACT_BYTE,   RAW_BYTE,    8'h00, 1, 8'd2, 1'b1, ST_NONE, 9'd0);
      add_row(ACT_BYTE,   CRC_LOW_OK,  8'h00, 0, 8'd0, 1'b0, ST_NONE, 9'd0);
      add_row(ACT_BYTE,   CRC_HIGH_OK, 8'h00, 0, 8'd0, 1'b0, ST_NONE, 9'd0);
      // address path at the count-limit code, bad CRC
      add_row(ACT_BYTE,   RAW_BYTE,    8'h01, 0, 8'd0, 1'b0, ST_NONE, 9'd0);
      add_row(ACT_BYTE,   RAW_BYTE,    8'h05, 0, 8'd0, 1'b0, ST_NONE, 9'd0);
      add_row(ACT_BYTE,   RAW_BYTE,    8'h00, 0, 8'd0, 1'b0, ST_NONE, 9'd0);
      add_row(ACT_BYTE,   RAW_BYTE,    8'hFF, 0, 8'd0, 1'b0, ST_NONE, 9'd0);
      add_row(ACT_BYTE,   RAW_BYTE,    8'h12, 0, 8'd0, 1'b0, ST_NONE, 9'd0);
      add_row(ACT_BYTE,   RAW_BYTE,    8'h34, 0, 8'd0, 1'b0, ST_NONE, 9'd0);
      add_row(ACT_BYTE,   RAW_BYTE,    8'h00, 0, 8'd0, 1'b0, ST_NONE, 9'd0);
      add_row(ACT_BYTE,   RAW_BYTE,    8'h00, 0, 8'd0, 1'b0, ST_NONE, 9'd0);
      // exception code: status is exception whatever the CRC
      add_row(ACT_BYTE,   RAW_BYTE,    8'h01, 0, 8'd0, 1'b0, ST_NONE, 9'd0);
      add_row(ACT_BYTE,   RAW_BYTE,    8'hFF, 0, 8'd0, 1'b0, ST_NONE, 9'd0);
      repeat (5)
         add_row(ACT_BYTE, RAW_BYTE,   8'h00, 0, 8'd0, 1'b0, ST_NONE, 9'd0);
      add_row(ACT_BYTE,   RAW_BYTE,    8'h00, 1, 8'd7, 1'b1, ST_EXCEPTION, 9'd8);

      foreach (dir_rows[i]) begin
         case (dir_rows[i].kind)
            CRC_LOW_OK:  b = crc[7:0];
            CRC_HIGH_OK: b = crc[15:8];
            default:     b = dir_rows[i].data;
         endcase
         send_item(dir_rows[i].act, b);
         if (dir_rows[i].typed)
            byte_reports[$] = dir_rows[i].want;
      end

      wait_idle();
      write_slave_address(8'h00);
      send_item(ACT_RESYNC, 8'h00);
      build_frame(8'h00, 251, 1);       // longest legal frame, 256 bytes
      send_bytes(frame_bytes.size());
      build_frame(8'h03, 255, 1);       // runs past the frame limit mid-data
      send_bytes(frame_bytes.size());
      send_item(ACT_RESYNC, 8'hFF);
      run_random(130);

      wait_idle();
      write_slave_address(8'hFF);
      send_idle_pct = 65;
      rcv_idle_pct  = 22;
      run_random(130);

      wait_idle();
      write_slave_address(8'($urandom_range(1, 254)));
      send_idle_pct = 0;
      rcv_idle_pct  = 0;
      send_item(ACT_RESYNC, 8'h00);
      build_frame(8'h01, 252, 1);       // limit hit on the last CRC byte
      send_bytes(frame_bytes.size());
      run_random(130);

      wait_idle();
      if (mismatches == 0 && byte_reports.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
